// ----- rtl/assert_macros.svh -----
// Assertion macros for the RTL files; lscp_ctrl includes them.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Property holds at every clock edge once reset is released.
`define ASSERT_ALWAYS(label, clk, rst_n, prop) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
		else $error("assertion failed");

// Antecedent implies consequent on the following clock edge.
`define ASSERT_NEXT(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("assertion failed");

`endif

// ----- rtl/lscp_pkg.sv -----
// ----------------------------------------------------------------------------
// lscp_pkg
// Types, constants and helper functions of the scene crossfade player.
// ----------------------------------------------------------------------------
package lscp_pkg;

	localparam int SCENE_DEPTH  = 64;
	localparam int TILE_DEPTH   = 16;
	localparam int SCENE_W      = $clog2(SCENE_DEPTH);
	localparam int TILE_W       = $clog2(TILE_DEPTH);
	localparam int COLOUR_DEPTH = SCENE_DEPTH * TILE_DEPTH;
	localparam int FRAC_W       = 17;
	localparam logic [FRAC_W-1:0] FRAC_ONE = 17'h10000;

	typedef enum logic [2:0] {
		CMD_SCENE  = 3'd0,
		CMD_COLOUR = 3'd1,
		CMD_ADDR   = 3'd2,
		CMD_START  = 3'd3,
		CMD_TICK   = 3'd4
	} cmd_e_t;

	typedef enum logic [1:0] {
		REG_SCENE_COUNT = 2'd0,
		REG_TILE_COUNT  = 2'd1,
		REG_SPEED       = 2'd2,
		REG_DIMMER      = 2'd3
	} cfg_reg_t;

	typedef enum logic [3:0] {
		ST_IDLE, ST_RD, ST_MUL, ST_CMP, ST_DIVS, ST_DIVW,
		ST_TRD, ST_TMUL1, ST_TMUL2, ST_TOUT
	} state_t;

	typedef struct packed {
		logic accept;
		logic do_mul;
		logic do_cmp;
		logic div_start;
		logic tile_inc;
		logic do_blend;
		logic do_dim;
	} dp_cmd_t;

	typedef struct packed {
		logic running;
		logic div_busy;
		logic no_tiles;
		logic last_tile;
	} dp_stat_t;

	// Next scene in the loop, wrapping at the number of scenes in use.
	function automatic logic [SCENE_W-1:0] scene_after(input logic [SCENE_W-1:0] s,
			input logic [6:0] cnt);
		logic [31:0] n;
		logic [31:0] lim;
		n   = {{(32-SCENE_W){1'b0}}, s} + 32'd1;
		lim = ({25'd0, cnt} > SCENE_DEPTH) ? SCENE_DEPTH : {25'd0, cnt};
		return (n >= lim) ? '0 : n[SCENE_W-1:0];
	endfunction

endpackage

// ----- rtl/led_scene_crossfade_player_core.sv -----
// A tick transfer while running steps through ST_RD, ST_MUL (two 24x16 products),
// ST_CMP, ST_DIVS and ST_DIVW; ST_DIVW waits on the restoring divider when the fade
// division runs. Each tile then steps through ST_TRD, ST_TMUL1, ST_TMUL2 and ST_TOUT.
// Store writes, start and ticks while stopped are handled in ST_IDLE without leaving it.
// Throughput is one command at a time; the next command is taken the cycle after the
// last tile transfer of a tick. Reset clears the controller and timing state, presets the
// config registers; the scene, colour and address stores are undefined until written.
// ----------------------------------------------------------------------------
// led_scene_crossfade_player_core
// Top level: looping RGB scene player with crossfade and dimmer.
// ----------------------------------------------------------------------------
module led_scene_crossfade_player_core (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        cfg_we,
	input  logic [1:0]  cfg_index,
	input  logic [15:0] cfg_wdata,
	input  logic        in_valid,
	output logic        in_ready,
	input  logic [2:0]  command,
	input  logic [5:0]  scene_index,
	input  logic [3:0]  tile_slot,
	input  logic [7:0]  tile_address,
	input  logic [23:0] hold_ticks,
	input  logic [23:0] fade_ticks,
	input  logic [7:0]  red_in,
	input  logic [7:0]  green_in,
	input  logic [7:0]  blue_in,
	output logic        out_valid,
	input  logic        out_ready,
	output logic [7:0]  tile_out_address,
	output logic [7:0]  red_out,
	output logic [7:0]  green_out,
	output logic [7:0]  blue_out,
	output logic [5:0]  playing_scene,
	output logic        fading,
	output logic        last_tile
);
	import lscp_pkg::*;

	dp_cmd_t  cmd;
	dp_stat_t stat;

	lscp_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_ready (in_ready),
		.command  (command),
		.out_valid(out_valid),
		.out_ready(out_ready),
		.cmd      (cmd),
		.stat     (stat)
	);

	lscp_datapath u_dp (
		.clk             (clk),
		.arst_n          (arst_n),
		.cmd             (cmd),
		.stat            (stat),
		.cfg_we          (cfg_we),
		.cfg_index       (cfg_index),
		.cfg_wdata       (cfg_wdata),
		.command         (command),
		.scene_index     (scene_index),
		.tile_slot       (tile_slot),
		.tile_address    (tile_address),
		.hold_ticks      (hold_ticks),
		.fade_ticks      (fade_ticks),
		.red_in          (red_in),
		.green_in        (green_in),
		.blue_in         (blue_in),
		.tile_out_address(tile_out_address),
		.red_out         (red_out),
		.green_out       (green_out),
		.blue_out        (blue_out),
		.playing_scene   (playing_scene),
		.fading          (fading),
		.last_tile       (last_tile)
	);

endmodule

// ----- rtl/lscp_div.sv -----
// ----------------------------------------------------------------------------
// lscp_div
// Restoring divider for the fade fraction, one quotient bit per cycle.
// The numerator never exceeds the denominator, so the quotient fits 17 bits.
// ----------------------------------------------------------------------------
module lscp_div (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       start,
	input  logic [39:0]                num,
	input  logic [39:0]                den,
	output logic                       busy,
	output logic [lscp_pkg::FRAC_W-1:0] quot
);
	import lscp_pkg::*;

	logic [40:0]        rem_q;
	logic [39:0]        den_q;
	logic [FRAC_W-1:0]  quot_q;
	logic [4:0]         cnt_q;
	logic               busy_q;
	logic               ge;
	logic [40:0]        rem_n;

	assign ge    = rem_q >= {1'b0, den_q};
	assign rem_n = ge ? (rem_q - {1'b0, den_q}) : rem_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			cnt_q  <= '0;
		end else if (start) begin
			busy_q <= 1'b1;
			cnt_q  <= 5'(FRAC_W);
		end else if (busy_q) begin
			cnt_q <= cnt_q - 5'd1;
			if (cnt_q == 5'd1) begin
				busy_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			rem_q  <= {1'b0, num};
			den_q  <= den;
			quot_q <= '0;
		end else if (busy_q) begin
			rem_q  <= {rem_n[39:0], 1'b0};
			quot_q <= {quot_q[FRAC_W-2:0], ge};
		end
	end

	assign busy = busy_q;
	assign quot = quot_q;

endmodule

// ----- rtl/lscp_datapath.sv -----
// ----------------------------------------------------------------------------
// lscp_datapath
// Scene, colour and address stores, timing arithmetic, fade blend and dimmer.
// ----------------------------------------------------------------------------
module lscp_datapath (
	input  logic                 clk,
	input  logic                 arst_n,
	input  lscp_pkg::dp_cmd_t    cmd,
	output lscp_pkg::dp_stat_t   stat,
	input  logic                 cfg_we,
	input  logic [1:0]           cfg_index,
	input  logic [15:0]          cfg_wdata,
	input  logic [2:0]           command,
	input  logic [5:0]           scene_index,
	input  logic [3:0]           tile_slot,
	input  logic [7:0]           tile_address,
	input  logic [23:0]          hold_ticks,
	input  logic [23:0]          fade_ticks,
	input  logic [7:0]           red_in,
	input  logic [7:0]           green_in,
	input  logic [7:0]           blue_in,
	output logic [7:0]           tile_out_address,
	output logic [7:0]           red_out,
	output logic [7:0]           green_out,
	output logic [7:0]           blue_out,
	output logic [5:0]           playing_scene,
	output logic                 fading,
	output logic                 last_tile
);
	import lscp_pkg::*;

	logic [6:0]  scene_count_q;
	logic [4:0]  tile_count_q;
	logic [15:0] speed_q;
	logic [8:0]  dimmer_q;

	logic [SCENE_W-1:0] cur_q, nxt_q;
	logic               phase_q, running_q;
	logic [31:0]        elapsed_q;

	logic [23:0] hold_mem [SCENE_DEPTH];
	logic [23:0] fade_mem [SCENE_DEPTH];
	logic [23:0] colour_mem [COLOUR_DEPTH];
	logic [7:0]  addr_mem [TILE_DEPTH];

	logic [23:0] hold_rd_q, fade_rd_q, col_a_q, col_b_q;
	logic [7:0]  addr_rd_q;
	logic [39:0] h_q, f_q, num_q;
	logic [FRAC_W-1:0] p_q;
	logic [TILE_W:0]   tile_q;
	logic [24:0] prod_q [3];
	logic [7:0]  base_q [3];
	logic        up_q [3];

	logic [TILE_W:0] tile_eff;
	logic [39:0]     e;
	logic [40:0]     hf;
	logic            ph1, fade_end, launch, div_busy, div_busy_d;
	logic [FRAC_W-1:0] quot;
	logic [SCENE_W+TILE_W-1:0] wr_addr;
	logic [7:0]  dim_val [3];

	logic w_scene, w_colour, w_addr;
	assign w_scene  = cmd.accept && command == CMD_SCENE
		&& {26'd0, scene_index} < SCENE_DEPTH;
	assign w_colour = cmd.accept && command == CMD_COLOUR
		&& {26'd0, scene_index} < SCENE_DEPTH && {28'd0, tile_slot} < TILE_DEPTH;
	assign w_addr   = cmd.accept && command == CMD_ADDR && {28'd0, tile_slot} < TILE_DEPTH;
	assign wr_addr  = {scene_index[SCENE_W-1:0], tile_slot[TILE_W-1:0]};

	assign tile_eff = ({27'd0, tile_count_q} > TILE_DEPTH) ? (TILE_W+1)'(TILE_DEPTH)
		: (TILE_W+1)'(tile_count_q);

	// Memories with registered reads.
	always_ff @(posedge clk) begin
		if (w_scene) begin
			hold_mem[scene_index[SCENE_W-1:0]] <= hold_ticks;
			fade_mem[scene_index[SCENE_W-1:0]] <= fade_ticks;
		end
		if (w_colour) begin
			colour_mem[wr_addr] <= {red_in, green_in, blue_in};
		end
		if (w_addr) begin
			addr_mem[tile_slot[TILE_W-1:0]] <= tile_address;
		end
		hold_rd_q <= hold_mem[cur_q];
		fade_rd_q <= fade_mem[cur_q];
		col_a_q   <= colour_mem[{cur_q, tile_q[TILE_W-1:0]}];
		col_b_q   <= colour_mem[{nxt_q, tile_q[TILE_W-1:0]}];
		addr_rd_q <= addr_mem[tile_q[TILE_W-1:0]];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			scene_count_q <= '0;
			tile_count_q  <= '0;
			speed_q       <= 16'd256;
			dimmer_q      <= 9'd256;
		end else if (cfg_we) begin
			unique case (cfg_reg_t'(cfg_index))
				REG_SCENE_COUNT: scene_count_q <= cfg_wdata[6:0];
				REG_TILE_COUNT:  tile_count_q  <= cfg_wdata[4:0];
				REG_SPEED:       speed_q       <= cfg_wdata;
				REG_DIMMER:      dimmer_q      <= cfg_wdata[8:0];
				default: ;
			endcase
		end
	end

	assign e        = {elapsed_q, 8'd0};
	assign hf       = {1'b0, h_q} + {1'b0, f_q};
	assign ph1      = phase_q || (e > h_q);
	assign fade_end = ph1 && ({1'b0, e} > hf);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cur_q     <= '0;
			nxt_q     <= '0;
			phase_q   <= 1'b0;
			elapsed_q <= '0;
			running_q <= 1'b0;
		end else if (cmd.accept && command == CMD_START) begin
			elapsed_q <= '0;
			phase_q   <= 1'b0;
			running_q <= 1'b1;
			nxt_q     <= scene_after(cur_q, scene_count_q);
		end else if (cmd.accept && command == CMD_TICK) begin
			if (elapsed_q != 32'hFFFF_FFFF) begin
				elapsed_q <= elapsed_q + 32'd1;
			end
		end else if (cmd.do_cmp) begin
			if (fade_end) begin
				elapsed_q <= '0;
				phase_q   <= 1'b0;
				cur_q     <= scene_after(cur_q, scene_count_q);
				nxt_q     <= scene_after(scene_after(cur_q, scene_count_q), scene_count_q);
			end else begin
				phase_q <= ph1;
			end
		end
	end

	assign launch = cmd.div_start && phase_q && (f_q != '0);

	lscp_div u_div (
		.clk   (clk),
		.arst_n(arst_n),
		.start (launch),
		.num   (num_q),
		.den   (f_q),
		.busy  (div_busy),
		.quot  (quot)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			div_busy_d <= 1'b0;
			tile_q     <= '0;
		end else begin
			div_busy_d <= div_busy;
			if (cmd.div_start) begin
				tile_q <= '0;
			end else if (cmd.tile_inc) begin
				tile_q <= tile_q + 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.do_mul) begin
			h_q <= hold_rd_q * speed_q;
			f_q <= fade_rd_q * speed_q;
		end
		if (cmd.do_cmp) begin
			num_q <= (e > h_q) ? (e - h_q) : '0;
		end
		if (cmd.div_start) begin
			p_q <= !phase_q ? '0 : FRAC_ONE;
		end else if (div_busy_d && !div_busy) begin
			p_q <= quot;
		end
	end

	// Blend: last colour plus or minus the scaled difference toward the next one.
	always_ff @(posedge clk) begin
		if (cmd.do_blend) begin
			for (int k = 0; k < 3; k++) begin
				logic [7:0] a, b, d;
				a = col_a_q[16-8*k +: 8];
				b = col_b_q[16-8*k +: 8];
				d = (a < b) ? (b - a) : (a - b);
				if (!phase_q) d = '0;
				base_q[k] <= a;
				up_q[k]   <= a < b;
				prod_q[k] <= d * p_q;
			end
		end
	end

	always_comb begin
		for (int k = 0; k < 3; k++) begin
			logic [24:0] v;
			logic [32:0] m;
			v = up_q[k] ? ({1'b0, base_q[k], 16'd0} + prod_q[k])
				: ({1'b0, base_q[k], 16'd0} - prod_q[k]);
			m = v[23:0] * dimmer_q;
			dim_val[k] = (m[32:24] > 9'd255) ? 8'd255 : m[31:24];
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.do_dim) begin
			red_out          <= dim_val[0];
			green_out        <= dim_val[1];
			blue_out         <= dim_val[2];
			tile_out_address <= addr_rd_q;
			playing_scene    <= 6'(cur_q);
			fading           <= phase_q;
			last_tile        <= stat.last_tile;
		end
	end

	assign stat.running   = running_q;
	assign stat.div_busy  = div_busy;
	assign stat.no_tiles  = tile_eff == '0;
	assign stat.last_tile = (tile_q + 1'b1) == tile_eff;

endmodule

// ----- rtl/lscp_ctrl.sv -----
// ----------------------------------------------------------------------------
// lscp_ctrl
// Sequencer for tick processing: timing, fade fraction and the tile walk.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module lscp_ctrl (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 in_valid,
	output logic                 in_ready,
	input  logic [2:0]           command,
	output logic                 out_valid,
	input  logic                 out_ready,
	output lscp_pkg::dp_cmd_t    cmd,
	input  lscp_pkg::dp_stat_t   stat
);
	import lscp_pkg::*;

	state_t state_q, state_n;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_n;
		end
	end

	always_comb begin
		state_n   = state_q;
		cmd       = '0;
		in_ready  = 1'b0;
		out_valid = 1'b0;
		unique case (state_q)
			ST_IDLE: begin
				in_ready   = 1'b1;
				cmd.accept = in_valid;
				if (in_valid && command == CMD_TICK && stat.running) begin
					state_n = ST_RD;
				end
			end
			ST_RD: state_n = ST_MUL;
			ST_MUL: begin
				cmd.do_mul = 1'b1;
				state_n    = ST_CMP;
			end
			ST_CMP: begin
				cmd.do_cmp = 1'b1;
				state_n    = ST_DIVS;
			end
			ST_DIVS: begin
				cmd.div_start = 1'b1;
				state_n       = ST_DIVW;
			end
			ST_DIVW: begin
				if (!stat.div_busy) begin
					state_n = stat.no_tiles ? ST_IDLE : ST_TRD;
				end
			end
			ST_TRD: state_n = ST_TMUL1;
			ST_TMUL1: begin
				cmd.do_blend = 1'b1;
				state_n      = ST_TMUL2;
			end
			ST_TMUL2: begin
				cmd.do_dim = 1'b1;
				state_n    = ST_TOUT;
			end
			ST_TOUT: begin
				out_valid = 1'b1;
				if (out_ready) begin
					if (stat.last_tile) begin
						state_n = ST_IDLE;
					end else begin
						cmd.tile_inc = 1'b1;
						state_n      = ST_TRD;
					end
				end
			end
			default: state_n = ST_IDLE;
		endcase
	end

	`ASSERT_ALWAYS(a_no_overlap, clk, arst_n, !(in_ready && out_valid))
	`ASSERT_ALWAYS(a_div_idle_start, clk, arst_n, !(cmd.div_start && stat.div_busy))
	`ASSERT_NEXT(a_last_to_idle, clk, arst_n,
		out_valid && out_ready && stat.last_tile, in_ready)

endmodule
